// ===== hdl/cb40_pkg.sv =====
// ----------------------------------------------------------------------------
// Callsign base-40 codec package
// Shared widths, codes, alphabet mapping, per-position constants and the
// record types that travel through the pipeline.
// ----------------------------------------------------------------------------
package cb40_pkg;

   localparam int CALLSIGN_CHARS = 9;
   localparam int CHAR_W         = 8;
   localparam int DIGIT_W        = 6;
   localparam int CODE_W         = 48;
   localparam int STATUS_W       = 2;
   localparam int POS_W          = $clog2(CALLSIGN_CHARS);
   localparam int SHIFT_W        = POS_W + 2;
   localparam int QX_W           = 24;
   localparam int RECIP_W        = 25;
   localparam int POW5_W         = 19;
   localparam int PROD_W         = QX_W + RECIP_W;
   localparam int MUL40_HI       = 5;
   localparam int MUL40_LO       = 3;

   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_NORMAL = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BCAST  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;

   localparam logic [CODE_W-1:0] CODE_ALL_ONES = 48'hffff_ffff_ffff;
   localparam logic [CODE_W-1:0] CODE_LIMIT    = 48'hee6b_27ff_ffff;

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_HASH  = 8'h23;
   localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2d;
   localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2e;
   localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2f;
   localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_L     = 8'h4c;
   localparam logic [CHAR_W-1:0] CHAR_Z     = 8'h5a;

   localparam logic [DIGIT_W-1:0] DIGIT_SPACE  = 6'd0;
   localparam logic [DIGIT_W-1:0] DIGIT_A      = 6'd1;
   localparam logic [DIGIT_W-1:0] DIGIT_Z      = 6'd26;
   localparam logic [DIGIT_W-1:0] DIGIT_NUM0   = 6'd27;
   localparam logic [DIGIT_W-1:0] DIGIT_NUM9   = 6'd36;
   localparam logic [DIGIT_W-1:0] DIGIT_DASH   = 6'd37;
   localparam logic [DIGIT_W-1:0] DIGIT_SLASH  = 6'd38;
   localparam logic [DIGIT_W-1:0] DIGIT_DOT    = 6'd39;

   typedef struct packed {
      logic                                   valid;
      logic                                   op;
      logic [STATUS_W-1:0]                    status;
      logic [CALLSIGN_CHARS-1:0][DIGIT_W-1:0] digits;
      logic [CODE_W-1:0]                      acc;
      logic [CODE_W-1:0]                      code;
   } stage_type;

   typedef struct packed {
      logic [CALLSIGN_CHARS-1:0][CHAR_W-1:0] chars;
      logic [CODE_W-1:0]                     code;
      logic [STATUS_W-1:0]                   status;
   } result_type;

   function automatic logic [DIGIT_W-1:0] sym_index(input logic [CHAR_W-1:0] c);
      logic [DIGIT_W-1:0] idx;
      idx = DIGIT_SPACE;
      if (c >= CHAR_A && c <= CHAR_Z) begin
         idx = DIGIT_W'(c - CHAR_A) + DIGIT_A;
      end else if (c >= CHAR_0 && c <= CHAR_9) begin
         idx = DIGIT_W'(c - CHAR_0) + DIGIT_NUM0;
      end else if (c == CHAR_DASH) begin
         idx = DIGIT_DASH;
      end else if (c == CHAR_SLASH) begin
         idx = DIGIT_SLASH;
      end else if (c == CHAR_DOT) begin
         idx = DIGIT_DOT;
      end
      return idx;
   endfunction

   function automatic logic [CHAR_W-1:0] sym_char(input logic [DIGIT_W-1:0] idx);
      logic [CHAR_W-1:0] c;
      c = CHAR_SPACE;
      if (idx >= DIGIT_A && idx <= DIGIT_Z) begin
         c = CHAR_A + CHAR_W'(idx - DIGIT_A);
      end else if (idx >= DIGIT_NUM0 && idx <= DIGIT_NUM9) begin
         c = CHAR_0 + CHAR_W'(idx - DIGIT_NUM0);
      end else if (idx == DIGIT_DASH) begin
         c = CHAR_DASH;
      end else if (idx == DIGIT_SLASH) begin
         c = CHAR_SLASH;
      end else if (idx == DIGIT_DOT) begin
         c = CHAR_DOT;
      end
      return c;
   endfunction

   // 5 to the power of the digit position; 40^p is 5^p shifted left by 3p.
   function automatic logic [POW5_W-1:0] pow5(input logic [POS_W-1:0] pos);
      logic [POW5_W-1:0] v;
      case (pos)
         4'd0:    v = 19'd1;
         4'd1:    v = 19'd5;
         4'd2:    v = 19'd25;
         4'd3:    v = 19'd125;
         4'd4:    v = 19'd625;
         4'd5:    v = 19'd3125;
         4'd6:    v = 19'd15625;
         4'd7:    v = 19'd78125;
         4'd8:    v = 19'd390625;
         default: v = 19'd1;
      endcase
      return v;
   endfunction

   // floor(2^24 / 5^p); the quotient estimate is low by at most one.
   function automatic logic [RECIP_W-1:0] recip(input logic [POS_W-1:0] pos);
      logic [RECIP_W-1:0] v;
      case (pos)
         4'd0:    v = 25'd16777216;
         4'd1:    v = 25'd3355443;
         4'd2:    v = 25'd671088;
         4'd3:    v = 25'd134217;
         4'd4:    v = 25'd26843;
         4'd5:    v = 25'd5368;
         4'd6:    v = 25'd1073;
         4'd7:    v = 25'd214;
         4'd8:    v = 25'd42;
         default: v = 25'd16777216;
      endcase
      return v;
   endfunction

endpackage

// ===== hdl/cb40_if.sv =====
// ----------------------------------------------------------------------------
// Callsign base-40 codec channels
// Valid/ready channels for requests and responses of the codec.
// ----------------------------------------------------------------------------
interface cb40_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [7:0]  char_0;
   logic [7:0]  char_1;
   logic [7:0]  char_2;
   logic [7:0]  char_3;
   logic [7:0]  char_4;
   logic [7:0]  char_5;
   logic [7:0]  char_6;
   logic [7:0]  char_7;
   logic [7:0]  char_8;
   logic [47:0] code_in;

   modport source (
      output valid, operation, char_0, char_1, char_2, char_3, char_4,
             char_5, char_6, char_7, char_8, code_in,
      input  ready
   );
   modport sink (
      input  valid, operation, char_0, char_1, char_2, char_3, char_4,
             char_5, char_6, char_7, char_8, code_in,
      output ready
   );
endinterface

interface cb40_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_char_0;
   logic [7:0]  out_char_1;
   logic [7:0]  out_char_2;
   logic [7:0]  out_char_3;
   logic [7:0]  out_char_4;
   logic [7:0]  out_char_5;
   logic [7:0]  out_char_6;
   logic [7:0]  out_char_7;
   logic [7:0]  out_char_8;
   logic [47:0] code_out;
   logic [1:0]  status;

   modport source (
      output valid, out_char_0, out_char_1, out_char_2, out_char_3, out_char_4,
             out_char_5, out_char_6, out_char_7, out_char_8, code_out, status,
      input  ready
   );
   modport sink (
      input  valid, out_char_0, out_char_1, out_char_2, out_char_3, out_char_4,
             out_char_5, out_char_6, out_char_7, out_char_8, code_out, status,
      output ready
   );
endinterface

// ===== hdl/cb40_front.sv =====
// ----------------------------------------------------------------------------
// Callsign base-40 codec input stage
// Maps text to digits, classifies the request and registers the record
// that enters the digit chain.
// ----------------------------------------------------------------------------
module cb40_front
   import cb40_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   cb40_req_if.sink   req_chan,
   output stage_type  stage_out
);

   logic [CALLSIGN_CHARS-1:0][CHAR_W-1:0]  chars;
   logic [CALLSIGN_CHARS-1:0]              in_text;
   logic [CALLSIGN_CHARS-1:0][DIGIT_W-1:0] enc_digits;
   logic                                   is_all_text;
   stage_type                              s0_in;
   stage_type                              s0_ff;

   always_comb begin
      chars[0] = req_chan.char_0;
      chars[1] = req_chan.char_1;
      chars[2] = req_chan.char_2;
      chars[3] = req_chan.char_3;
      chars[4] = req_chan.char_4;
      chars[5] = req_chan.char_5;
      chars[6] = req_chan.char_6;
      chars[7] = req_chan.char_7;
      chars[8] = req_chan.char_8;
   end

   // The text ends at the first NUL.
   always_comb begin
      in_text[0] = (chars[0] != CHAR_NUL);
      for (int k = 1; k < CALLSIGN_CHARS; k++) begin
         in_text[k] = in_text[k-1] && (chars[k] != CHAR_NUL);
      end
      for (int k = 0; k < CALLSIGN_CHARS; k++) begin
         enc_digits[k] = in_text[k] ? sym_index(chars[k]) : DIGIT_SPACE;
      end
   end

   assign is_all_text = (chars[0] == CHAR_HASH) && (chars[1] == CHAR_A) &&
                        (chars[2] == CHAR_L) && (chars[3] == CHAR_L);

   always_comb begin
      s0_in.valid = req_chan.valid;
      s0_in.op    = req_chan.operation;
      s0_in.code  = req_chan.code_in;
      if (req_chan.operation == OP_ENCODE) begin
         s0_in.status = is_all_text ? STATUS_BCAST : STATUS_NORMAL;
         s0_in.digits = enc_digits;
         s0_in.acc    = '0;
      end else begin
         if (req_chan.code_in == CODE_ALL_ONES) begin
            s0_in.status = STATUS_BCAST;
         end else if (req_chan.code_in > CODE_LIMIT) begin
            s0_in.status = STATUS_RANGE;
         end else begin
            s0_in.status = STATUS_NORMAL;
         end
         s0_in.digits = '0;
         s0_in.acc    = req_chan.code_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.valid <= 1'b0;
      end else if (advance) begin
         s0_ff <= s0_in;
      end
   end

   assign req_chan.ready = advance;
   assign stage_out      = s0_ff;

endmodule

// ===== hdl/cb40_cell.sv =====
// ----------------------------------------------------------------------------
// Callsign base-40 codec digit cell
// Handles one digit position in two register stages. Encoding folds the
// digit into the running code; decoding splits the digit off the rest with
// a reciprocal multiply and a single correction step.
// ----------------------------------------------------------------------------
module cb40_cell
   import cb40_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic [POS_W-1:0] pos,
   input  stage_type        stage_in,
   output stage_type        stage_out
);

   logic [SHIFT_W-1:0] shift;
   logic [CODE_W-1:0]  in_shifted;
   logic [PROD_W-1:0]  prod_in;
   logic [PROD_W-1:0]  prod_ff;
   stage_type          a_ff;
   stage_type          b_in;
   stage_type          b_ff;

   logic [CODE_W-1:0]  a_shifted;
   logic [QX_W-1:0]    x_b;
   logic [DIGIT_W-1:0] q_est;
   logic [QX_W-1:0]    divisor;
   logic [QX_W-1:0]    qd;
   logic [QX_W-1:0]    rem0;
   logic               fix;
   logic [DIGIT_W-1:0] q;
   logic [QX_W-1:0]    rem;
   logic [CODE_W-1:0]  low_mask;
   logic [CODE_W-1:0]  acc_dec;
   logic [CODE_W-1:0]  acc_enc;

   // Dividing by 40^p is a shift by 3p followed by a division by 5^p.
   assign shift      = SHIFT_W'({pos, 1'b0}) + SHIFT_W'(pos);
   assign in_shifted = stage_in.acc >> shift;
   assign prod_in    = PROD_W'(in_shifted[QX_W-1:0]) * PROD_W'(recip(pos));

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
      end else if (advance) begin
         a_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      a_shifted = a_ff.acc >> shift;
      x_b       = a_shifted[QX_W-1:0];
      q_est     = prod_ff[QX_W +: DIGIT_W];
      divisor   = QX_W'(pow5(pos));
      qd        = QX_W'(q_est) * divisor;
      rem0      = x_b - qd;
      fix       = (rem0 >= divisor);
      q         = fix ? q_est + DIGIT_W'(1) : q_est;
      rem       = fix ? rem0 - divisor : rem0;
      low_mask  = (CODE_W'(1) << shift) - CODE_W'(1);
      acc_dec   = (CODE_W'(rem) << shift) | (a_ff.acc & low_mask);
      acc_enc   = (a_ff.acc << MUL40_HI) + (a_ff.acc << MUL40_LO) +
                  CODE_W'(a_ff.digits[pos]);

      b_in = a_ff;
      if (a_ff.op == OP_DECODE) begin
         b_in.acc         = acc_dec;
         b_in.digits[pos] = q;
      end else begin
         b_in.acc = acc_enc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff.valid <= 1'b0;
      end else if (advance) begin
         b_ff <= b_in;
      end
   end

   assign stage_out = b_ff;

endmodule

// ===== hdl/cb40_back.sv =====
// ----------------------------------------------------------------------------
// Callsign base-40 codec output stage
// Builds the normalized text, code and status, and holds results in an
// output register with a skid entry behind it.
// ----------------------------------------------------------------------------
module cb40_back
   import cb40_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  stage_type   stage_in,
   output logic        advance,
   cb40_rsp_if.source  rsp_chan
);

   logic [CALLSIGN_CHARS:0] live;
   result_type              result;
   result_type              out_ff;
   result_type              out_in;
   result_type              skid_ff;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   logic                    skid_valid_ff;
   logic                    skid_valid_in;
   logic                    out_load;
   logic                    skid_load;
   logic                    pop;
   logic                    take;

   // A position carries a character only if it or a higher one is nonzero.
   always_comb begin
      live[CALLSIGN_CHARS] = 1'b0;
      for (int k = CALLSIGN_CHARS - 1; k >= 0; k--) begin
         live[k] = live[k+1] || (stage_in.digits[k] != DIGIT_SPACE);
      end

      result.chars  = '0;
      result.status = stage_in.status;
      result.code   = '0;
      case (stage_in.status)
         STATUS_BCAST: begin
            result.chars[0] = CHAR_HASH;
            result.chars[1] = CHAR_A;
            result.chars[2] = CHAR_L;
            result.chars[3] = CHAR_L;
            result.code     = CODE_ALL_ONES;
         end
         STATUS_NORMAL: begin
            for (int k = 0; k < CALLSIGN_CHARS; k++) begin
               result.chars[k] = live[k] ? sym_char(stage_in.digits[k]) : CHAR_NUL;
            end
            result.code = (stage_in.op == OP_ENCODE) ? stage_in.acc : stage_in.code;
         end
         default: begin
            result.chars = '0;
            result.code  = '0;
         end
      endcase
   end

   assign advance = !skid_valid_ff;
   assign pop     = out_valid_ff && rsp_chan.ready;
   assign take    = advance && stage_in.valid;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_load      = 1'b0;
      skid_load     = 1'b0;
      out_in        = result;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_load      = 1'b1;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_load     = take;
            out_valid_in = take;
         end
      end else if (take) begin
         skid_load     = 1'b1;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= out_in;
      end
      if (skid_load) begin
         skid_ff <= result;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.out_char_0 = out_ff.chars[0];
   assign rsp_chan.out_char_1 = out_ff.chars[1];
   assign rsp_chan.out_char_2 = out_ff.chars[2];
   assign rsp_chan.out_char_3 = out_ff.chars[3];
   assign rsp_chan.out_char_4 = out_ff.chars[4];
   assign rsp_chan.out_char_5 = out_ff.chars[5];
   assign rsp_chan.out_char_6 = out_ff.chars[6];
   assign rsp_chan.out_char_7 = out_ff.chars[7];
   assign rsp_chan.out_char_8 = out_ff.chars[8];
   assign rsp_chan.code_out   = out_ff.code;
   assign rsp_chan.status     = out_ff.status;

endmodule

// ===== hdl/callsign_base40_codec.sv =====
// ----------------------------------------------------------------------------
// Callsign base-40 codec
// Converts between a nine-character callsign and its 48-bit base-40 code.
//
// Requests arrive on req_chan (operation, char_0..char_8, code_in) and
// results leave on rsp_chan (out_char_0..out_char_8, code_out, status),
// both valid/ready channels; a transfer happens when valid and ready are
// both high at a rising clock edge.
// One request gives exactly one response, in order. A new request can be
// taken in every cycle while req_chan.ready is high. The path runs through
// one input register and a row of nine digit cells, one per character
// position, each two register stages deep; each cell holds one reciprocal
// multiplier, used for decoding.
// Responses wait in an output register with one skid entry. When the
// receiver stalls, the skid entry fills and req_chan.ready drops until a
// response transfer frees it; the whole pipeline holds meanwhile.
// The synchronous reset empties the pipeline and both output entries.
// ----------------------------------------------------------------------------
module callsign_base40_codec
   import cb40_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   cb40_req_if.sink    req_chan,
   cb40_rsp_if.source  rsp_chan
);

   logic      advance;
   stage_type chain [CALLSIGN_CHARS+1];

   cb40_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .req_chan  (req_chan),
      .stage_out (chain[0])
   );

   // Cells run from the most significant position down to position zero.
   for (genvar j = 0; j < CALLSIGN_CHARS; j++) begin : g_cell
      cb40_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .pos       (POS_W'(CALLSIGN_CHARS - 1 - j)),
         .stage_in  (chain[j]),
         .stage_out (chain[j+1])
      );
   end

   cb40_back u_back (
      .clock    (clock),
      .reset    (reset),
      .stage_in (chain[CALLSIGN_CHARS]),
      .advance  (advance),
      .rsp_chan (rsp_chan)
   );

   // The input side only stalls while a finished response is waiting.
   a_stall_needs_backlog: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_chan.valid)
      else $error("request side stalled with no response pending");

   // A stall ends only through a response transfer.
   a_stall_release: assert property (@(posedge clock) disable iff (reset)
      ($rose(req_chan.ready) && !$past(reset)) |->
         $past(rsp_chan.valid && rsp_chan.ready))
      else $error("request side resumed without a response transfer");

   a_range_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == STATUS_RANGE) |->
         (rsp_chan.code_out == '0 && rsp_chan.out_char_0 == CHAR_NUL))
      else $error("out-of-range response carries a code or text");

   a_bcast_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == STATUS_BCAST) |->
         (rsp_chan.code_out == CODE_ALL_ONES && rsp_chan.out_char_0 == CHAR_HASH))
      else $error("broadcast response malformed");

endmodule
